// ----- src/trd_pkg.sv -----
`default_nettype none
package trd_pkg;

  localparam logic [7:0] V2Marker = 8'h80;
  localparam logic [15:0] MaxBodyReset = 16'd16499;

  localparam logic [7:0] CtCcs = 8'd20;
  localparam logic [7:0] CtAlert = 8'd21;
  localparam logic [7:0] CtHandshake = 8'd22;
  localparam logic [7:0] CtAppData = 8'd23;

  localparam logic [2:0] PhRec = 3'd0;
  localparam logic [2:0] PhMsgStart = 3'd1;
  localparam logic [2:0] PhMsgHdr = 3'd2;
  localparam logic [2:0] PhMsgBody = 3'd3;
  localparam logic [2:0] PhTrail = 3'd4;
  localparam logic [2:0] PhErr = 3'd5;

  typedef enum logic [2:0] {
    KindRecHdr = 3'd0,
    KindMsgHdr = 3'd1,
    KindMsgBody = 3'd2,
    KindTrail = 3'd3,
    KindDiscard = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StBadVersion = 3'd1,
    StBadLength = 3'd2,
    StTooShort = 3'd3,
    StOutOfBound = 3'd4,
    StUnknownType = 3'd5,
    StV2NotHello = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    RegExpectFinished = 2'd0,
    RegMaxBodyLen = 2'd1
  } reg_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic [7:0] record_type;
    logic [1:0] record_version;
    logic [7:0] message_type;
    logic type_known;
    logic [23:0] message_length;
    logic message_start;
    logic message_end;
    logic record_end;
    logic [2:0] status;
  } result_t;

endpackage
`default_nettype wire

// ----- src/trd_if.sv -----
`default_nettype none
interface trd_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface trd_out_if;
  logic valid;
  logic ready;
  trd_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trd_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- src/trd_parser.sv -----
`default_nettype none
module trd_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  output trd_pkg::result_t       res_o
);

  logic exp_fin_q, exp_fin_d;
  logic [15:0] max_len_q, max_len_d;
  logic [2:0] phase_q, phase_d;
  logic [2:0] hcnt_q, hcnt_d;
  logic [7:0] rtype_q, rtype_d;
  logic [1:0] ver_q, ver_d;
  logic [15:0] brem_q, brem_d;
  logic [2:0] mhc_q, mhc_d;
  logic [7:0] mtype_q, mtype_d;
  logic [23:0] mrem_q, mrem_d;
  logic [23:0] mlen_q, mlen_d;
  logic fin_q, fin_d;
  logic [2:0] err_q, err_d;
  logic v2_q, v2_d;
  logic known_q, known_d;
  logic major_q, major_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_fin_q <= 1'b0;
      max_len_q <= trd_pkg::MaxBodyReset;
      phase_q <= trd_pkg::PhRec;
      hcnt_q <= '0;
      rtype_q <= '0;
      ver_q <= '0;
      brem_q <= '0;
      mhc_q <= '0;
      mtype_q <= '0;
      mrem_q <= '0;
      mlen_q <= '0;
      fin_q <= 1'b0;
      err_q <= trd_pkg::StOk;
      v2_q <= 1'b0;
      known_q <= 1'b0;
      major_q <= 1'b0;
    end else begin
      exp_fin_q <= exp_fin_d;
      max_len_q <= max_len_d;
      phase_q <= phase_d;
      hcnt_q <= hcnt_d;
      rtype_q <= rtype_d;
      ver_q <= ver_d;
      brem_q <= brem_d;
      mhc_q <= mhc_d;
      mtype_q <= mtype_d;
      mrem_q <= mrem_d;
      mlen_q <= mlen_d;
      fin_q <= fin_d;
      err_q <= err_d;
      v2_q <= v2_d;
      known_q <= known_d;
      major_q <= major_d;
    end
  end

  always_comb begin
    exp_fin_d = exp_fin_q;
    max_len_d = max_len_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        trd_pkg::RegExpectFinished: exp_fin_d = cfg_data_i[0];
        trd_pkg::RegMaxBodyLen:     max_len_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // one byte of parsing; control flags mirror the record/message walk
  logic [2:0] kind;
  logic ms, me, re, hdr_fields, do_body, do_end_msg;
  logic [15:0] len;
  logic [2:0] new_mhc;

  always_comb begin
    phase_d = phase_q;
    hcnt_d = hcnt_q;
    rtype_d = rtype_q;
    ver_d = ver_q;
    brem_d = brem_q;
    mhc_d = mhc_q;
    mtype_d = mtype_q;
    mrem_d = mrem_q;
    mlen_d = mlen_q;
    fin_d = fin_q;
    err_d = err_q;
    v2_d = v2_q;
    known_d = known_q;
    major_d = major_q;
    kind = trd_pkg::KindRecHdr;
    ms = 1'b0;
    me = 1'b0;
    re = 1'b0;
    hdr_fields = 1'b0;
    do_body = 1'b0;
    do_end_msg = 1'b0;
    len = {brem_q[15:8], byte_i};
    new_mhc = mhc_q + 3'd1;

    unique case (phase_q)
      trd_pkg::PhRec: begin
        hdr_fields = 1'b1;
        if (hcnt_q == 3'd0) begin
          v2_d = (byte_i == trd_pkg::V2Marker);
          rtype_d = v2_d ? 8'd0 : byte_i;
          ver_d = '0;
          hcnt_d = 3'd1;
        end else if (v2_q) begin
          if (byte_i == 8'd0) begin
            err_d = trd_pkg::StTooShort;
            phase_d = trd_pkg::PhErr;
          end else begin
            brem_d = {8'd0, byte_i};
            hcnt_d = '0;
            phase_d = trd_pkg::PhMsgStart;
          end
        end else if (hcnt_q == 3'd1) begin
          major_d = (byte_i == 8'd3);
          hcnt_d = 3'd2;
        end else if (hcnt_q == 3'd2) begin
          if (major_q && byte_i == 8'd0) begin
            ver_d = 2'd1;
            hcnt_d = 3'd3;
          end else if (major_q && byte_i == 8'd1) begin
            ver_d = 2'd2;
            hcnt_d = 3'd3;
          end else begin
            err_d = trd_pkg::StBadVersion;
            phase_d = trd_pkg::PhErr;
          end
        end else if (hcnt_q == 3'd3) begin
          brem_d = {byte_i, 8'd0};
          hcnt_d = 3'd4;
        end else begin
          if (len > max_len_q) begin
            err_d = trd_pkg::StBadLength;
            phase_d = trd_pkg::PhErr;
          end else if (rtype_q < trd_pkg::CtCcs || rtype_q > trd_pkg::CtAppData) begin
            err_d = trd_pkg::StUnknownType;
            phase_d = trd_pkg::PhErr;
          end else begin
            brem_d = len;
            hcnt_d = '0;
            if (len == 16'd0) begin
              hdr_fields = 1'b0;
              if (rtype_q == trd_pkg::CtAppData ||
                  (rtype_q == trd_pkg::CtHandshake && exp_fin_q)) begin
                re = 1'b1;
                phase_d = trd_pkg::PhRec;
              end else begin
                err_d = trd_pkg::StTooShort;
                phase_d = trd_pkg::PhErr;
              end
            end else begin
              phase_d = trd_pkg::PhMsgStart;
            end
          end
        end
      end
      trd_pkg::PhMsgStart: begin
        ms = 1'b1;
        known_d = 1'b1;
        mhc_d = '0;
        if (v2_q) begin
          if (byte_i != 8'd1) begin
            err_d = trd_pkg::StV2NotHello;
            phase_d = trd_pkg::PhErr;
          end else begin
            rtype_d = 8'd1;
            mtype_d = 8'd1;
            mlen_d = {8'd0, brem_q};
            do_body = 1'b1;
          end
        end else if (rtype_q == trd_pkg::CtHandshake) begin
          if (exp_fin_q) begin
            known_d = 1'b0;
            mtype_d = 8'd0;
            mlen_d = {8'd0, brem_q};
            do_body = 1'b1;
          end else if (brem_q < 16'd4) begin
            err_d = trd_pkg::StTooShort;
            phase_d = trd_pkg::PhErr;
          end else begin
            mtype_d = byte_i;
            mlen_d = '0;
            mrem_d = '0;
            mhc_d = 3'd1;
            brem_d = brem_q - 16'd1;
            kind = trd_pkg::KindMsgHdr;
            phase_d = trd_pkg::PhMsgHdr;
          end
        end else if (rtype_q == trd_pkg::CtAlert) begin
          if (brem_q < 16'd2) begin
            err_d = trd_pkg::StTooShort;
            phase_d = trd_pkg::PhErr;
          end else begin
            mtype_d = trd_pkg::CtAlert;
            mlen_d = 24'd2;
            do_body = 1'b1;
          end
        end else if (rtype_q == trd_pkg::CtCcs) begin
          mtype_d = trd_pkg::CtCcs;
          mlen_d = 24'd1;
          do_body = 1'b1;
        end else begin
          mtype_d = trd_pkg::CtAppData;
          mlen_d = {8'd0, brem_q};
          do_body = 1'b1;
        end
        if (do_body) mrem_d = mlen_d;
      end
      trd_pkg::PhMsgHdr: begin
        kind = trd_pkg::KindMsgHdr;
        brem_d = brem_q - 16'd1;
        mrem_d = {mrem_q[15:0], byte_i};
        mhc_d = new_mhc;
        if (new_mhc >= 3'd4) begin
          if (mrem_d > {8'd0, brem_d}) begin
            err_d = trd_pkg::StOutOfBound;
            phase_d = trd_pkg::PhErr;
          end else begin
            mlen_d = mrem_d + 24'd4;
            if (mrem_d == 24'd0) do_end_msg = 1'b1;
            else phase_d = trd_pkg::PhMsgBody;
          end
        end
      end
      trd_pkg::PhMsgBody: do_body = 1'b1;
      trd_pkg::PhTrail: begin
        kind = trd_pkg::KindTrail;
        brem_d = brem_q - 16'd1;
        if (brem_d == 16'd0) begin
          re = 1'b1;
          phase_d = trd_pkg::PhRec;
          hcnt_d = '0;
        end
      end
      default: phase_d = trd_pkg::PhErr;
    endcase

    if (do_body) begin
      kind = trd_pkg::KindMsgBody;
      mrem_d = mrem_d - 24'd1;
      brem_d = brem_d - 16'd1;
      if (mrem_d == 24'd0 || brem_d == 16'd0) do_end_msg = 1'b1;
      else phase_d = trd_pkg::PhMsgBody;
    end
    if (do_end_msg) begin
      me = 1'b1;
      fin_d = known_d && mtype_d == trd_pkg::CtCcs;
      if (brem_d == 16'd0) begin
        re = 1'b1;
        phase_d = trd_pkg::PhRec;
        hcnt_d = '0;
      end else if (!v2_q && fin_d) begin
        phase_d = trd_pkg::PhTrail;
      end else begin
        phase_d = trd_pkg::PhMsgStart;
      end
    end

    res_o = '0;
    res_o.out_byte = byte_i;
    res_o.status = err_d;
    if (phase_d == trd_pkg::PhErr) begin
      res_o.byte_kind = trd_pkg::KindDiscard;
    end else begin
      res_o.byte_kind = kind;
      res_o.message_start = ms;
      res_o.message_end = me;
      res_o.record_end = re;
      if (phase_q != trd_pkg::PhRec || hdr_fields) begin
        res_o.record_type = rtype_d;
        res_o.record_version = ver_d;
      end
      if (kind == trd_pkg::KindMsgHdr || kind == trd_pkg::KindMsgBody) begin
        res_o.message_type = mtype_d;
        res_o.type_known = known_d;
        res_o.message_length = mlen_d;
      end
    end

    // hold state when no byte is taken
    if (!step_i) begin
      phase_d = phase_q;
      hcnt_d = hcnt_q;
      rtype_d = rtype_q;
      ver_d = ver_q;
      brem_d = brem_q;
      mhc_d = mhc_q;
      mtype_d = mtype_q;
      mrem_d = mrem_q;
      mlen_d = mlen_q;
      fin_d = fin_q;
      err_d = err_q;
      v2_d = v2_q;
      known_d = known_q;
      major_d = major_q;
    end
  end

endmodule
`default_nettype wire

// ----- src/trd_queue.sv -----
`default_nettype none
module trd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire trd_pkg::result_t  push_data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output trd_pkg::result_t       head_o
);

  trd_pkg::result_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;
  assign head_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ----- src/tls_record_deframer.sv -----
// tls record deframer
// in_i carries one received byte per request; out_o returns one tagged result
// per byte, in order: kind of byte, record and message context, start/end
// flags and a sticky status. cfg_i writes expect_finished (index 0) and
// max_body_len (index 1); write only while no byte is in flight.
// a byte is parsed in the cycle it is accepted and its result is registered
// into a two-entry result queue whose head drives out_o.
// in_i takes one byte per cycle while the result queue is not full.
// when the receiver stalls the queue fills after two results and in_i.ready
// drops until a result is taken; nothing is lost or repeated.
// reset (rst_ni low) returns the parser to waiting for a record header,
// clears any error, empties the queue and restores the default registers.
// after an error every byte is still accepted and reported as discarded.
`default_nettype none
module tls_record_deframer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  trd_in_if.sink    in_i,
  trd_out_if.source out_o,
  trd_cfg_if.sink   cfg_i
);

  trd_pkg::result_t res;
  logic full;
  logic step;

  assign in_i.ready = !full;
  assign cfg_i.ready = 1'b1;
  assign step = in_i.valid && !full;

  trd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_i.in_byte),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.wdata),
    .res_o      (res)
  );

  trd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (res),
    .full_o      (full),
    .valid_o     (out_o.valid),
    .pop_i       (out_o.ready),
    .head_o      (out_o.data)
  );

  a_status_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status != trd_pkg::StOk
      |-> out_o.data.byte_kind == trd_pkg::KindDiscard)
    else $error("error status on a byte that is not discarded");

  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.data.status != trd_pkg::StOk
      |=> !out_o.valid || out_o.data.status == $past(out_o.data.status))
    else $error("error status changed without reset");

  a_start_in_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.message_start
      |-> out_o.data.byte_kind == trd_pkg::KindMsgHdr ||
          out_o.data.byte_kind == trd_pkg::KindMsgBody)
    else $error("message start outside a message");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !out_o.ready |=> !out_o.valid || full || !$past(in_i.valid))
    else $error("queue overflow");

endmodule
`default_nettype wire
